// File: hdl/pscp_pkg.sv
// Package: payload types, coordinate width and register indexes of the closest point block.
`timescale 1ns / 1ps
package pscp_pkg;

    localparam int CW = 16;

    localparam logic [1:0] RegStartX = 2'd0;
    localparam logic [1:0] RegStartY = 2'd1;
    localparam logic [1:0] RegEndX   = 2'd2;
    localparam logic [1:0] RegEndY   = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 clamp_to_segment;
    } req_t;

    typedef struct packed {
        logic signed [CW-1:0] closest_x;
        logic signed [CW-1:0] closest_y;
        logic [16:0]          distance_out;
        logic                 degenerate;
        logic                 saturated;
    } res_t;

endpackage

// File: hdl/point_segment_closest_point.sv
// Closest point on a configured 2D segment or line, with distance: pipelined top level.
// The longest parts of the pipeline are the one-bit-a-stage divider and the 17-stage square root.
// Throughput: one request per cycle, busy is always low; the receiver cannot stall.
// Reset: asynchronous, active low; clears the valid bits and the segment registers to 0.
`timescale 1ns / 1ps
module point_segment_closest_point #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  pscp_pkg::req_t         req,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [pscp_pkg::CW-1:0] cfg_data,
    output logic                   done,
    output pscp_pkg::res_t         result
);

    localparam int CW   = pscp_pkg::CW;
    localparam int TF   = T_FRAC_BITS;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int LW   = 2 * CW + 2;
    localparam int DOTW = 2 * CW + 3;
    localparam int MW   = 2 * CW + 2;
    localparam int NW   = MW + TF + 1;
    localparam int TW   = CW + TF + 4;
    localparam int PRW  = DW + TW;
    localparam int OW   = PRW - TF + 2;
    localparam int SW   = 2 * DW;
    localparam int SQN  = SW / 2;
    localparam int RW   = SQN + 3;

    localparam logic [NW-1:0] TLim = NW'(1) << (CW + TF + 2);
    localparam logic signed [TW-1:0] TOne = TW'(1) << TF;
    localparam logic [PRW-1:0] RHalf = PRW'(1) << (TF - 1);
    localparam logic signed [OW-1:0] CMax = OW'((1 << (CW - 1)) - 1);
    localparam logic signed [OW-1:0] CMin = -OW'(1 << (CW - 1));

    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 clamp;
    } side_t;

    typedef struct packed {
        logic [LW:0]   rem;
        logic [NW-1:0] num;
        logic [NW-1:0] q;
        logic [LW-1:0] len2;
        logic          neg;
        logic          degen;
        side_t         sd;
    } div_t;

    typedef struct packed {
        logic [SW-1:0]        x;
        logic [SQN-1:0]       r;
        logic [RW-1:0]        rem;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic                 degen;
        logic                 clipped;
    } sq_t;

    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pscp_pkg::RegStartX: ax_reg <= cfg_data;
                pscp_pkg::RegStartY: ay_reg <= cfg_data;
                pscp_pkg::RegEndX:   bx_reg <= cfg_data;
                pscp_pkg::RegEndY:   by_reg <= cfg_data;
                default:             ax_reg <= ax_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: differences
    logic                 v1_reg;
    side_t                s1_reg;
    logic signed [DW-1:0] vx1_reg, vy1_reg;

    always_ff @(posedge clk)
    begin
        s1_reg.dx    <= DW'(bx_reg) - DW'(ax_reg);
        s1_reg.dy    <= DW'(by_reg) - DW'(ay_reg);
        s1_reg.ax    <= ax_reg;
        s1_reg.ay    <= ay_reg;
        s1_reg.px    <= req.point_x;
        s1_reg.py    <= req.point_y;
        s1_reg.clamp <= req.clamp_to_segment;
        vx1_reg      <= DW'(req.point_x) - DW'(ax_reg);
        vy1_reg      <= DW'(req.point_y) - DW'(ay_reg);
    end

    // stage 2: products
    logic                 v2_reg;
    side_t                s2_reg;
    logic signed [PW-1:0] pxx_reg, pyy_reg, pvx_reg, pvy_reg;

    always_ff @(posedge clk)
    begin
        s2_reg  <= s1_reg;
        pxx_reg <= s1_reg.dx * s1_reg.dx;
        pyy_reg <= s1_reg.dy * s1_reg.dy;
        pvx_reg <= vx1_reg * s1_reg.dx;
        pvy_reg <= vy1_reg * s1_reg.dy;
    end

    // stage 3: squared length and dot product
    logic                   v3_reg;
    side_t                  s3_reg;
    logic [LW-1:0]          len2_reg;
    logic signed [DOTW-1:0] dot_reg;
    logic signed [PW:0]     len2_sum;

    assign len2_sum = (PW+1)'(pxx_reg) + (PW+1)'(pyy_reg);

    always_ff @(posedge clk)
    begin
        s3_reg   <= s2_reg;
        len2_reg <= len2_sum[LW-1:0];
        dot_reg  <= DOTW'(pvx_reg) + DOTW'(pvy_reg);
    end

    // stage 4 and divider: restoring division, one quotient bit a stage
    div_t        dv_reg [NW+1];
    div_t        dv_next [NW+1];
    logic [NW:0] dvv_reg;
    logic [MW-1:0] abs_dot;
    logic [DOTW-1:0] neg_dot;

    assign neg_dot = -dot_reg;
    assign abs_dot = dot_reg[DOTW-1] ? neg_dot[MW-1:0] : dot_reg[MW-1:0];

    always_comb
    begin
        dv_next[0].rem   = '0;
        dv_next[0].num   = NW'({abs_dot, {TF{1'b0}}}) + NW'(len2_reg >> 1);
        dv_next[0].q     = '0;
        dv_next[0].len2  = len2_reg;
        dv_next[0].neg   = dot_reg[DOTW-1];
        dv_next[0].degen = (len2_reg == '0);
        dv_next[0].sd    = s3_reg;
        for (int k = 1; k <= NW; k++)
        begin
            logic [LW:0] sh;
            sh = {dv_reg[k-1].rem[LW-1:0], dv_reg[k-1].num[NW-1]};
            dv_next[k] = dv_reg[k-1];
            dv_next[k].num = dv_reg[k-1].num << 1;
            if (sh >= {1'b0, dv_reg[k-1].len2})
            begin
                dv_next[k].rem = sh - {1'b0, dv_reg[k-1].len2};
                dv_next[k].q   = {dv_reg[k-1].q[NW-2:0], 1'b1};
            end
            else
            begin
                dv_next[k].rem = sh;
                dv_next[k].q   = {dv_reg[k-1].q[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NW; k++)
        begin
            dv_reg[k] <= dv_next[k];
        end
    end

    // stage 5: signed, magnitude-limited t, clamped to [0, 1] when clamp is set
    div_t                 dl;
    logic                 v5_reg;
    logic signed [TW-1:0] tq_reg;
    side_t                s5_reg;
    logic                 dg5_reg;
    logic [TW-1:0]        t_mag;
    logic signed [TW-1:0] t_next;

    assign dl    = dv_reg[NW];
    assign t_mag = (dl.q > TLim) ? TLim[TW-1:0] : dl.q[TW-1:0];

    always_comb
    begin
        t_next = dl.neg ? -$signed(t_mag) : $signed(t_mag);
        if (dl.sd.clamp)
        begin
            if (t_next < 0)
            begin
                t_next = '0;
            end
            if (t_next > TOne)
            begin
                t_next = TOne;
            end
        end
        if (dl.degen)
        begin
            t_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        tq_reg  <= t_next;
        s5_reg  <= dl.sd;
        dg5_reg <= dl.degen;
    end

    // stage 6: offsets along the segment
    logic                  v6_reg;
    logic signed [PRW-1:0] ox_reg, oy_reg;
    side_t                 s6_reg;
    logic                  dg6_reg;

    always_ff @(posedge clk)
    begin
        ox_reg  <= s5_reg.dx * tq_reg;
        oy_reg  <= s5_reg.dy * tq_reg;
        s6_reg  <= s5_reg;
        dg6_reg <= dg5_reg;
    end

    // stage 7: round, add start point, saturate
    function automatic logic signed [OW-1:0] round_add(
        input logic signed [PRW-1:0] p,
        input logic signed [CW-1:0]  a
    );
        logic [PRW-1:0]        mag;
        logic [PRW-1:0]        s;
        logic signed [OW-1:0]  off;
        mag = p[PRW-1] ? PRW'(-p) : PRW'(p);
        s   = mag + RHalf;
        off = OW'(s[PRW-1:TF]);
        if (p[PRW-1])
        begin
            off = -off;
        end
        return OW'(a) + off;
    endfunction

    logic                 v7_reg;
    logic signed [CW-1:0] cx7_reg, cy7_reg, px7_reg, py7_reg;
    logic                 dg7_reg, cl7_reg;
    logic signed [OW-1:0] cx_full, cy_full;
    logic signed [CW-1:0] cx_sat, cy_sat;
    logic                 clip_x, clip_y;

    assign cx_full = round_add(ox_reg, s6_reg.ax);
    assign cy_full = round_add(oy_reg, s6_reg.ay);

    always_comb
    begin
        clip_x = (cx_full > CMax) || (cx_full < CMin);
        clip_y = (cy_full > CMax) || (cy_full < CMin);
        cx_sat = (cx_full > CMax) ? CMax[CW-1:0] :
                 (cx_full < CMin) ? CMin[CW-1:0] : cx_full[CW-1:0];
        cy_sat = (cy_full > CMax) ? CMax[CW-1:0] :
                 (cy_full < CMin) ? CMin[CW-1:0] : cy_full[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        cx7_reg <= cx_sat;
        cy7_reg <= cy_sat;
        px7_reg <= s6_reg.px;
        py7_reg <= s6_reg.py;
        dg7_reg <= dg6_reg;
        cl7_reg <= clip_x | clip_y;
    end

    // stage 8: error vector
    logic                 v8_reg;
    logic signed [DW-1:0] ex_reg, ey_reg;
    logic signed [CW-1:0] cx8_reg, cy8_reg;
    logic                 dg8_reg, cl8_reg;

    always_ff @(posedge clk)
    begin
        ex_reg  <= DW'(px7_reg) - DW'(cx7_reg);
        ey_reg  <= DW'(py7_reg) - DW'(cy7_reg);
        cx8_reg <= cx7_reg;
        cy8_reg <= cy7_reg;
        dg8_reg <= dg7_reg;
        cl8_reg <= cl7_reg;
    end

    // stage 9: squares
    logic                 v9_reg;
    logic signed [PW-1:0] exx_reg, eyy_reg;
    logic signed [CW-1:0] cx9_reg, cy9_reg;
    logic                 dg9_reg, cl9_reg;

    always_ff @(posedge clk)
    begin
        exx_reg <= ex_reg * ex_reg;
        eyy_reg <= ey_reg * ey_reg;
        cx9_reg <= cx8_reg;
        cy9_reg <= cy8_reg;
        dg9_reg <= dg8_reg;
        cl9_reg <= cl8_reg;
    end

    // square root: two radicand bits a stage
    sq_t          sq_reg [SQN+1];
    sq_t          sq_next [SQN+1];
    logic [SQN:0] sqv_reg;

    always_comb
    begin
        sq_next[0].x       = SW'(exx_reg) + SW'(eyy_reg);
        sq_next[0].r       = '0;
        sq_next[0].rem     = '0;
        sq_next[0].cx      = cx9_reg;
        sq_next[0].cy      = cy9_reg;
        sq_next[0].degen   = dg9_reg;
        sq_next[0].clipped = cl9_reg;
        for (int k = 1; k <= SQN; k++)
        begin
            logic [RW-1:0] rs;
            logic [RW-1:0] trial;
            rs    = {sq_reg[k-1].rem[RW-3:0], sq_reg[k-1].x[SW-1 -: 2]};
            trial = RW'({sq_reg[k-1].r, 2'b01});
            sq_next[k]   = sq_reg[k-1];
            sq_next[k].x = sq_reg[k-1].x << 2;
            if (rs >= trial)
            begin
                sq_next[k].rem = rs - trial;
                sq_next[k].r   = {sq_reg[k-1].r[SQN-2:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem = rs;
                sq_next[k].r   = {sq_reg[k-1].r[SQN-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= SQN; k++)
        begin
            sq_reg[k] <= sq_next[k];
        end
    end

    // output register
    pscp_pkg::res_t res_reg;
    logic           done_reg;
    sq_t            sl;

    assign sl = sq_reg[SQN];

    always_ff @(posedge clk)
    begin
        res_reg.closest_x    <= sl.cx;
        res_reg.closest_y    <= sl.cy;
        res_reg.distance_out <= (sl.rem > RW'(sl.r)) ? 17'(sl.r) + 17'd1 : 17'(sl.r);
        res_reg.degenerate   <= sl.degen;
        res_reg.saturated    <= sl.clipped;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            dvv_reg  <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v8_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            sqv_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            dvv_reg  <= {dvv_reg[NW-1:0], v3_reg};
            v5_reg   <= dvv_reg[NW];
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v8_reg   <= v7_reg;
            v9_reg   <= v8_reg;
            sqv_reg  <= {sqv_reg[SQN-1:0], v9_reg};
            done_reg <= sqv_reg[SQN];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
